/* rtl/core/rhp_pkg.sv */
// Shared constants, codes and width helpers for the refcounted handle pool.
`default_nettype none

package rhp_pkg;

  localparam int ARENA_SLOTS_DEF = 256;
  localparam int MAX_ARENAS_DEF  = 8;
  localparam int REF_WIDTH_DEF   = 16;

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  localparam int ARENA_W   = 3;
  localparam int SLOT_F_W  = 8;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 12;

  localparam int WORD_BITS_MAX_W = 5;

  localparam logic [IN_TUSER_W-1:0] KIND_CREATE  = 2'd0;
  localparam logic [IN_TUSER_W-1:0] KIND_GET     = 2'd1;
  localparam logic [IN_TUSER_W-1:0] KIND_RELEASE = 2'd2;
  localparam logic [IN_TUSER_W-1:0] KIND_DESTROY = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_REFERENCED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FATAL      = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_ARENAS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_FREE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_FAIL       = 2'd2;

  localparam logic [CFG_DATA_W-1:0] ACTIVE_ARENAS_RESET = 4'd2;

  function automatic int slot_width(input int slots);
    return (slots > 1) ? $clog2(slots) : 1;
  endfunction

  function automatic int bit_width(input int slots);
    return (slot_width(slots) > WORD_BITS_MAX_W) ? WORD_BITS_MAX_W : slot_width(slots);
  endfunction

  function automatic int word_index_width(input int slots);
    return (slot_width(slots) > WORD_BITS_MAX_W) ? slot_width(slots) - WORD_BITS_MAX_W : 1;
  endfunction

  function automatic int arena_width(input int arenas);
    return (arenas > 1) ? $clog2(arenas) : 1;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/refcounted_handle_pool_core.sv */
// Top level of the refcounted handle pool: sequencer, slot memory and counters.
//
//   channel   dir  handshake           contents
//   s_*       in   s_tvalid/s_tready   s_tuser: kind; s_tdata: arena, slot, payload
//   m_*       out  m_tvalid/m_tready   m_tdata: status, arena, slot, payload, used, free
//   cfg_*     in   cfg_we              cfg_index selects register, cfg_data value
//
// One item at a time; n = live arenas, i.e. active_arenas clamped to 1..MAX_ARENAS. Get,
// release, destroy: accept, check, sum the used counts of the n arenas, then output; a bad
// handle skips the check. Create swaps the check for a probe of each arena in turn and a
// scan of its bitmap words (32 bits by default). After reset a clearing pass writes zero to
// every bitmap word with s_tready low.
// s_tready is low while an item is in work and while its result waits on m_tready.
`default_nettype none

module refcounted_handle_pool_core #(
  parameter int ARENA_SLOTS = rhp_pkg::ARENA_SLOTS_DEF,
  parameter int MAX_ARENAS  = rhp_pkg::MAX_ARENAS_DEF,
  parameter int REF_WIDTH   = rhp_pkg::REF_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // arena[2:0], slot[10:3], payload[42:11], zero fill
  input  wire logic [rhp_pkg::IN_TDATA_W-1:0]     s_tdata,
  // kind[1:0]
  input  wire logic [rhp_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // status[2:0], arena[5:3], slot[13:6], payload[45:14], used[57:46], free[69:58]
  output logic      [rhp_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [rhp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rhp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SLOT_W = rhp_pkg::slot_width(ARENA_SLOTS);
  localparam int BIT_W  = rhp_pkg::bit_width(ARENA_SLOTS);
  localparam int WPA_W  = rhp_pkg::word_index_width(ARENA_SLOTS);
  localparam int BW     = 1 << BIT_W;
  localparam int AW     = rhp_pkg::arena_width(MAX_ARENAS);
  localparam int BA_W   = AW + WPA_W;
  localparam int DA_W   = AW + SLOT_W;
  localparam int DDEPTH = 1 << DA_W;
  localparam int LIVE_W = $clog2(MAX_ARENAS + 1);
  localparam int CW     = (LIVE_W > rhp_pkg::CFG_DATA_W) ? LIVE_W : rhp_pkg::CFG_DATA_W;
  localparam int HW     = (LIVE_W > rhp_pkg::ARENA_W) ? LIVE_W : rhp_pkg::ARENA_W;
  localparam int UW     = $clog2(ARENA_SLOTS + 1);
  localparam int SUMW   = $clog2(MAX_ARENAS * ARENA_SLOTS + 1);
  localparam int DW     = rhp_pkg::PAYLOAD_W + REF_WIDTH;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FIND, S_SCAN, S_CHECK, S_SUM, S_OUT
  } state_t;

  state_t state;

  logic [rhp_pkg::CFG_DATA_W-1:0] active_arenas;
  logic                           auto_free;
  logic                           no_fail;

  logic [UW-1:0] arena_used [MAX_ARENAS];
  logic [AW-1:0] search_arena;

  logic [BA_W-1:0]   clr_cnt;
  logic [AW-1:0]     ai;
  logic [AW-1:0]     si;
  logic [LIVE_W-1:0] k;
  logic [WPA_W-1:0]  wi;
  logic [SLOT_W-1:0] slot_r;
  logic [rhp_pkg::IN_TUSER_W-1:0] kind_r;
  logic [rhp_pkg::PAYLOAD_W-1:0]  payload_r;
  logic [SUMW-1:0]   used_sum;

  logic [rhp_pkg::STATUS_W-1:0]  status_r;
  logic [rhp_pkg::ARENA_W-1:0]   out_arena_r;
  logic [rhp_pkg::SLOT_F_W-1:0]  out_slot_r;
  logic [rhp_pkg::PAYLOAD_W-1:0] out_payload_r;
  logic [SUMW-1:0]               used_r;
  logic [SUMW-1:0]               free_r;

  logic [DW-1:0] dmem [DDEPTH];
  logic [DW-1:0] dq;
  logic [DA_W-1:0] dm_raddr;
  logic [DA_W-1:0] dm_waddr;
  logic [DW-1:0]   dm_wdata;
  logic            dm_we;

  logic [BA_W-1:0] bm_raddr;
  logic [BA_W-1:0] bm_waddr;
  logic [BW-1:0]   bm_wdata;
  logic [BW-1:0]   bm_rdata;
  logic            bm_we;
  logic            free_any;
  logic [BIT_W-1:0] free_pos;

  logic [rhp_pkg::ARENA_W-1:0]   in_arena;
  logic [rhp_pkg::SLOT_F_W-1:0]  in_slot;
  logic [rhp_pkg::PAYLOAD_W-1:0] in_payload;
  logic [rhp_pkg::IN_TUSER_W-1:0] in_kind;
  logic [SLOT_W-1:0] in_slot_t;
  logic [WPA_W-1:0]  in_word;
  logic [WPA_W-1:0]  slot_word;

  logic [CW-1:0]     act_ext;
  logic [LIVE_W-1:0] live;
  logic [LIVE_W-1:0] live_m1;
  logic              handle_ok;
  logic [AW-1:0]     start_arena;
  logic [AW-1:0]     next_ai;
  logic [AW-1:0]     au_idx;
  logic [UW-1:0]     au;
  logic [SLOT_W-1:0] new_slot;
  logic [SUMW-1:0]   sum_next;
  logic [SUMW-1:0]   free_calc;

  logic [REF_WIDTH-1:0]          refs_q;
  logic [rhp_pkg::PAYLOAD_W-1:0] pay_q;
  logic                          valid_bit;
  logic [rhp_pkg::STATUS_W-1:0]  chk_status;
  logic [REF_WIDTH-1:0]          chk_refs;
  logic                          chk_dwe;
  logic                          chk_free;

  rhp_bitmap #(
    .ARENA_SLOTS (ARENA_SLOTS),
    .MAX_ARENAS  (MAX_ARENAS)
  ) u_bitmap (
    .clk      (clk),
    .raddr    (bm_raddr),
    .we       (bm_we),
    .waddr    (bm_waddr),
    .wdata    (bm_wdata),
    .rdata    (bm_rdata),
    .free_any (free_any),
    .free_pos (free_pos)
  );

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
    dq <= dmem[dm_raddr];
  end

  assign in_arena   = s_tdata[2:0];
  assign in_slot    = s_tdata[10:3];
  assign in_payload = s_tdata[42:11];
  assign in_kind    = s_tuser;
  assign in_slot_t  = SLOT_W'(in_slot);
  assign in_word    = WPA_W'(in_slot_t >> BIT_W);
  assign slot_word  = WPA_W'(slot_r >> BIT_W);

  assign act_ext = CW'(active_arenas);
  assign live    = (active_arenas == '0) ? LIVE_W'(1) :
                   ((act_ext > CW'(MAX_ARENAS)) ? LIVE_W'(MAX_ARENAS) : LIVE_W'(act_ext));
  assign live_m1 = live - LIVE_W'(1);

  assign handle_ok = (HW'(in_arena) < HW'(live)) && (32'(in_slot) < 32'(ARENA_SLOTS));

  assign start_arena = (LIVE_W'(search_arena) < live) ? search_arena : '0;
  assign next_ai     = ((LIVE_W'(ai) + LIVE_W'(1)) < live) ? ai + AW'(1) : '0;
  assign au_idx      = (state == S_SUM) ? si : ai;
  assign au          = arena_used[au_idx];
  assign new_slot    = SLOT_W'({wi, free_pos});
  assign sum_next    = used_sum + SUMW'(au);
  assign free_calc   = SUMW'(live) * SUMW'(ARENA_SLOTS) - sum_next;

  assign refs_q    = dq[REF_WIDTH-1:0];
  assign pay_q     = dq[DW-1:REF_WIDTH];
  assign valid_bit = bm_rdata[slot_r[BIT_W-1:0]];

  always_comb begin
    chk_status = rhp_pkg::STAT_OK;
    chk_refs   = refs_q;
    chk_dwe    = 1'b0;
    chk_free   = 1'b0;
    case (kind_r)
      rhp_pkg::KIND_GET: begin
        if (!valid_bit || refs_q == '0) begin
          chk_status = rhp_pkg::STAT_NOT_FOUND;
        end else if (refs_q == '1) begin
          chk_status = rhp_pkg::STAT_FATAL;
        end else begin
          chk_refs = refs_q + REF_WIDTH'(1);
          chk_dwe  = 1'b1;
        end
      end
      rhp_pkg::KIND_RELEASE: begin
        if (!valid_bit || refs_q == '0) begin
          chk_status = rhp_pkg::STAT_NOT_FOUND;
        end else begin
          chk_refs = refs_q - REF_WIDTH'(1);
          chk_dwe  = 1'b1;
          chk_free = auto_free && (refs_q == REF_WIDTH'(1));
        end
      end
      rhp_pkg::KIND_DESTROY: begin
        if (!valid_bit) begin
          chk_status = rhp_pkg::STAT_NOT_FOUND;
        end else if (refs_q != '0) begin
          chk_status = rhp_pkg::STAT_REFERENCED;
        end else begin
          chk_free = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    bm_raddr = {ai, wi + WPA_W'(1)};
    bm_we    = 1'b0;
    bm_waddr = {ai, wi};
    bm_wdata = bm_rdata;
    dm_raddr = {AW'(in_arena), in_slot_t};
    dm_we    = 1'b0;
    dm_waddr = {ai, new_slot};
    dm_wdata = {payload_r, REF_WIDTH'(1)};
    case (state)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_cnt;
        bm_wdata = '0;
      end
      S_IDLE: begin
        bm_raddr = {AW'(in_arena), in_word};
      end
      S_FIND: begin
        bm_raddr = {ai, WPA_W'(0)};
      end
      S_SCAN: begin
        if (free_any) begin
          bm_we    = 1'b1;
          bm_wdata = bm_rdata | (BW'(1) << free_pos);
          dm_we    = 1'b1;
        end
      end
      S_CHECK: begin
        dm_waddr = {ai, slot_r};
        dm_wdata = {pay_q, chk_refs};
        dm_we    = chk_dwe;
        bm_waddr = {ai, slot_word};
        bm_wdata = bm_rdata & ~(BW'(1) << slot_r[BIT_W-1:0]);
        bm_we    = chk_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      search_arena  <= '0;
      active_arenas <= rhp_pkg::ACTIVE_ARENAS_RESET;
      auto_free     <= 1'b1;
      no_fail       <= 1'b0;
      for (int i = 0; i < MAX_ARENAS; i++) begin
        arena_used[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rhp_pkg::CFG_ACTIVE_ARENAS: active_arenas <= cfg_data;
          rhp_pkg::CFG_AUTO_FREE:     auto_free     <= cfg_data[0];
          rhp_pkg::CFG_NO_FAIL:       no_fail       <= cfg_data[0];
          default: begin
          end
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + BA_W'(1);
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            kind_r        <= in_kind;
            payload_r     <= in_payload;
            status_r      <= rhp_pkg::STAT_OK;
            out_arena_r   <= '0;
            out_slot_r    <= '0;
            out_payload_r <= '0;
            si            <= '0;
            used_sum      <= '0;
            if (in_kind == rhp_pkg::KIND_CREATE) begin
              ai    <= start_arena;
              k     <= '0;
              state <= S_FIND;
            end else if (!handle_ok) begin
              status_r <= rhp_pkg::STAT_NOT_FOUND;
              state    <= S_SUM;
            end else begin
              ai     <= AW'(in_arena);
              slot_r <= in_slot_t;
              state  <= S_CHECK;
            end
          end
        end
        S_FIND: begin
          if (au < UW'(ARENA_SLOTS)) begin
            wi    <= '0;
            state <= S_SCAN;
          end else if (k == live_m1) begin
            status_r <= rhp_pkg::STAT_FULL;
            state    <= S_SUM;
          end else begin
            ai <= next_ai;
            k  <= k + LIVE_W'(1);
          end
        end
        S_SCAN: begin
          if (free_any) begin
            arena_used[ai] <= au + UW'(1);
            search_arena   <= ai;
            out_arena_r    <= rhp_pkg::ARENA_W'(ai);
            out_slot_r     <= rhp_pkg::SLOT_F_W'(new_slot);
            state          <= S_SUM;
          end else begin
            wi <= wi + WPA_W'(1);
          end
        end
        S_CHECK: begin
          status_r <= chk_status;
          if (kind_r == rhp_pkg::KIND_GET && chk_status == rhp_pkg::STAT_OK) begin
            out_payload_r <= pay_q;
          end
          if (chk_free && au != '0) begin
            arena_used[ai] <= au - UW'(1);
          end
          state <= S_SUM;
        end
        S_SUM: begin
          used_sum <= sum_next;
          si       <= si + AW'(1);
          if (LIVE_W'(si) == live_m1) begin
            used_r <= sum_next;
            free_r <= free_calc;
            if (no_fail && status_r != rhp_pkg::STAT_OK) begin
              status_r <= rhp_pkg::STAT_FATAL;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {2'b00,
                     rhp_pkg::COUNT_W'(free_r),
                     rhp_pkg::COUNT_W'(used_r),
                     out_payload_r,
                     out_slot_r,
                     out_arena_r,
                     status_r};

endmodule

`default_nettype wire

/* rtl/core/rhp_bitmap.sv */
// Slot occupancy bitmap memory with lowest-free-bit finder on the read word.
`default_nettype none

module rhp_bitmap #(
  parameter int ARENA_SLOTS = rhp_pkg::ARENA_SLOTS_DEF,
  parameter int MAX_ARENAS  = rhp_pkg::MAX_ARENAS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic [rhp_pkg::arena_width(MAX_ARENAS)
                     + rhp_pkg::word_index_width(ARENA_SLOTS)-1:0] raddr,
  input  wire logic                                       we,
  input  wire logic [rhp_pkg::arena_width(MAX_ARENAS)
                     + rhp_pkg::word_index_width(ARENA_SLOTS)-1:0] waddr,
  input  wire logic [(1 << rhp_pkg::bit_width(ARENA_SLOTS))-1:0]    wdata,
  output logic      [(1 << rhp_pkg::bit_width(ARENA_SLOTS))-1:0]    rdata,
  output logic                                            free_any,
  output logic      [rhp_pkg::bit_width(ARENA_SLOTS)-1:0] free_pos
);

  localparam int BIT_W = rhp_pkg::bit_width(ARENA_SLOTS);
  localparam int WPA_W = rhp_pkg::word_index_width(ARENA_SLOTS);
  localparam int AW    = rhp_pkg::arena_width(MAX_ARENAS);
  localparam int BA_W  = AW + WPA_W;
  localparam int BW    = 1 << BIT_W;
  localparam int DEPTH = 1 << BA_W;

  logic [BW-1:0]    mem [DEPTH];
  logic [WPA_W-1:0] rword;
  logic [BW-1:0]    free_vec;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
    rword <= raddr[WPA_W-1:0];
  end

  // mask slots beyond the arena size
  always_comb begin
    for (int b = 0; b < BW; b++) begin
      free_vec[b] = !rdata[b] && (((int'(rword) << BIT_W) + b) < ARENA_SLOTS);
    end
  end

  always_comb begin
    free_any = |free_vec;
    free_pos = '0;
    for (int b = BW - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        free_pos = BIT_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

/* tb/sv/refcounted_handle_pool_core_test.sv */
// Self-checking testbench for refcounted_handle_pool_core: directed, saturation and random traffic.
module refcounted_handle_pool_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = rhp_pkg::ARENA_SLOTS_DEF;
  localparam int ARENAS = rhp_pkg::MAX_ARENAS_DEF;
  localparam int TOTAL = SLOTS * ARENAS;
  localparam int REF_MAX = (1 << rhp_pkg::REF_WIDTH_DEF) - 1;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [rhp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [rhp_pkg::CFG_DATA_W-1:0] ARENA_PLAN [10] =
    '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd2, 4'd5, 4'd8, 4'd4, 4'd7};

  typedef struct packed {
    logic [rhp_pkg::IN_TUSER_W-1:0] kind;
    logic [rhp_pkg::ARENA_W-1:0] arena;
    logic [rhp_pkg::SLOT_F_W-1:0] slot;
    logic [rhp_pkg::PAYLOAD_W-1:0] payload;
  } pool_request_t;

  typedef struct packed {
    logic [rhp_pkg::STATUS_W-1:0] status;
    logic [rhp_pkg::ARENA_W-1:0] arena;
    logic [rhp_pkg::SLOT_F_W-1:0] slot;
    logic [rhp_pkg::PAYLOAD_W-1:0] payload;
    logic [rhp_pkg::COUNT_W-1:0] used;
    logic [rhp_pkg::COUNT_W-1:0] free_cnt;
  } pool_result_t;

  class handle_pool_scoreboard;
    logic [rhp_pkg::PAYLOAD_W-1:0] payload_mem [TOTAL];
    int unsigned refs [TOTAL];
    bit valid [TOTAL];
    int unsigned arena_fill [ARENAS];
    int unsigned search_start;
    logic [rhp_pkg::CFG_DATA_W-1:0] arenas_reg;
    bit auto_free_reg;
    bit no_fail_reg;
    pool_result_t awaited [$];
    int unsigned errors;

    function new();
      foreach (payload_mem[i]) begin
        payload_mem[i] = '0;
        refs[i] = 0;
        valid[i] = 1'b0;
      end
      foreach (arena_fill[a]) arena_fill[a] = 0;
      search_start = 0;
      arenas_reg = rhp_pkg::ACTIVE_ARENAS_RESET;
      auto_free_reg = 1'b1;
      no_fail_reg = 1'b0;
      errors = 0;
    endfunction

    function int unsigned live_arenas();
      if (arenas_reg == 0) return 1;
      if (arenas_reg > ARENAS) return ARENAS;
      return 32'(arenas_reg);
    endfunction

    function void write_reg(logic [rhp_pkg::CFG_INDEX_W-1:0] idx,
                            logic [rhp_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        rhp_pkg::CFG_ACTIVE_ARENAS: arenas_reg = value;
        rhp_pkg::CFG_AUTO_FREE: auto_free_reg = value[0];
        rhp_pkg::CFG_NO_FAIL: no_fail_reg = value[0];
        default: ;
      endcase
    endfunction

    function void drop_slot(int unsigned a, int unsigned idx);
      valid[idx] = 1'b0;
      refs[idx] = 0;
      if (arena_fill[a] > 0) arena_fill[a]--;
    endfunction

    function void note_request(pool_request_t req);
      pool_result_t res;
      int unsigned n, a, idx, j, used;
      bit placed;
      res = '0;
      n = live_arenas();
      idx = req.arena * SLOTS + req.slot;
      if (req.kind == rhp_pkg::KIND_CREATE) begin
        res.status = rhp_pkg::STAT_FULL;
        a = (search_start < n) ? search_start : 0;
        placed = 1'b0;
        for (int k = 0; k < n && !placed; k++) begin
          if (arena_fill[a] < SLOTS) begin
            for (int s = 0; s < SLOTS && !placed; s++) begin
              j = a * SLOTS + s;
              if (!valid[j] && refs[j] == 0) begin
                valid[j] = 1'b1;
                refs[j] = 1;
                payload_mem[j] = req.payload;
                arena_fill[a]++;
                search_start = a;
                res.status = rhp_pkg::STAT_OK;
                res.arena = rhp_pkg::ARENA_W'(a);
                res.slot = rhp_pkg::SLOT_F_W'(s);
                placed = 1'b1;
              end
            end
          end
          if (!placed) a = (a + 1 < n) ? a + 1 : 0;
        end
      end else if (req.arena >= n) begin
        res.status = rhp_pkg::STAT_NOT_FOUND;
      end else if (req.kind == rhp_pkg::KIND_GET) begin
        if (!valid[idx] || refs[idx] == 0) res.status = rhp_pkg::STAT_NOT_FOUND;
        else if (refs[idx] >= REF_MAX) res.status = rhp_pkg::STAT_FATAL;
        else begin
          refs[idx]++;
          res.payload = payload_mem[idx];
        end
      end else if (req.kind == rhp_pkg::KIND_RELEASE) begin
        if (!valid[idx] || refs[idx] == 0) res.status = rhp_pkg::STAT_NOT_FOUND;
        else begin
          refs[idx]--;
          if (auto_free_reg && refs[idx] == 0) drop_slot(32'(req.arena), idx);
        end
      end else begin
        if (refs[idx] != 0) res.status = rhp_pkg::STAT_REFERENCED;
        else if (!valid[idx]) res.status = rhp_pkg::STAT_NOT_FOUND;
        else drop_slot(32'(req.arena), idx);
      end
      if (no_fail_reg && res.status != rhp_pkg::STAT_OK) res.status = rhp_pkg::STAT_FATAL;
      used = 0;
      for (int i = 0; i < n; i++) used += arena_fill[i];
      res.used = rhp_pkg::COUNT_W'(used);
      res.free_cnt = rhp_pkg::COUNT_W'(n * SLOTS - used);
      awaited.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(pool_result_t got);
      pool_result_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_arena", 32'(want.arena), 32'(got.arena));
      compare_field("out_slot", 32'(want.slot), 32'(got.slot));
      compare_field("out_payload", want.payload, got.payload);
      compare_field("used_count", 32'(want.used), 32'(got.used));
      compare_field("free_count", 32'(want.free_cnt), 32'(got.free_cnt));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rhp_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic [rhp_pkg::IN_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [rhp_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [rhp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rhp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bit idle_on = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  handle_pool_scoreboard sb;

  refcounted_handle_pool_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic pool_result_t unpack_result(logic [rhp_pkg::OUT_TDATA_W-1:0] d);
    pool_result_t r;
    r.status = d[2:0];
    r.arena = d[5:3];
    r.slot = d[13:6];
    r.payload = d[45:14];
    r.used = d[57:46];
    r.free_cnt = d[69:58];
    return r;
  endfunction

  initial begin : result_sink
    int unsigned stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (rst || m_tvalid !== 1'b1 || !m_tready);
      sb.check_result(unpack_result(m_tdata));
    end
  end

  task automatic send_item(input logic [rhp_pkg::IN_TUSER_W-1:0] kind,
                           input logic [rhp_pkg::ARENA_W-1:0] arena,
                           input logic [rhp_pkg::SLOT_F_W-1:0] slot,
                           input logic [rhp_pkg::PAYLOAD_W-1:0] payload);
    pool_request_t req;
    int unsigned gap;
    req = {kind, arena, slot, payload};
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {5'b0, payload, slot, arena};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_request(req);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [rhp_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [rhp_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(input logic [rhp_pkg::CFG_DATA_W-1:0] arenas, input bit af,
                           input bit nf);
    drain();
    put_reg(rhp_pkg::CFG_ACTIVE_ARENAS, arenas);
    put_reg(rhp_pkg::CFG_AUTO_FREE, {3'b0, af});
    put_reg(rhp_pkg::CFG_NO_FAIL, {3'b0, nf});
    put_reg(CFG_UNUSED, rhp_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick, n, tries;
    logic [rhp_pkg::IN_TUSER_W-1:0] kind;
    logic [rhp_pkg::ARENA_W-1:0] a;
    logic [rhp_pkg::SLOT_F_W-1:0] s;
    pick = $urandom_range(0, 99);
    n = sb.live_arenas();
    a = rhp_pkg::ARENA_W'($urandom);
    s = rhp_pkg::SLOT_F_W'($urandom);
    if (pick < 30) kind = rhp_pkg::KIND_CREATE;
    else if (pick < 55) kind = rhp_pkg::KIND_GET;
    else if (pick < 85) kind = rhp_pkg::KIND_RELEASE;
    else kind = rhp_pkg::KIND_DESTROY;
    // mostly live handles, the rest raw noise
    if (kind != rhp_pkg::KIND_CREATE && pick % 10 != 0) begin
      a = rhp_pkg::ARENA_W'($urandom_range(0, n - 1));
      tries = 0;
      while (!sb.valid[a * SLOTS + s] && tries < 32) begin
        a = rhp_pkg::ARENA_W'($urandom_range(0, n - 1));
        s = rhp_pkg::SLOT_F_W'($urandom);
        tries++;
      end
    end
    send_item(kind, a, s, $urandom);
  endtask

  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    send_item(rhp_pkg::KIND_GET, 3'd0, 8'd0, 32'h0);
    send_item(rhp_pkg::KIND_RELEASE, 3'd0, 8'd0, 32'h0);
    send_item(rhp_pkg::KIND_DESTROY, 3'd0, 8'd0, 32'h0);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, 32'h0000_0000);
    send_item(rhp_pkg::KIND_CREATE, 3'd7, 8'd255, 32'hFFFF_FFFF);
    send_item(rhp_pkg::KIND_GET, 3'd0, 8'd1, 32'hFFFF_FFFF);
    send_item(rhp_pkg::KIND_DESTROY, 3'd0, 8'd1, 32'h0);
    send_item(rhp_pkg::KIND_RELEASE, 3'd0, 8'd1, 32'h0);
    send_item(rhp_pkg::KIND_GET, 3'd7, 8'd255, 32'h0);
    send_item(rhp_pkg::KIND_GET, 3'd1, 8'd255, 32'h0);
    send_item(rhp_pkg::KIND_RELEASE, 3'd0, 8'd1, 32'h0);
    send_item(rhp_pkg::KIND_GET, 3'd0, 8'd0, 32'h0);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, 32'hA5A5_A5A5);
    configure(4'd2, 1'b0, 1'b0);
    send_item(rhp_pkg::KIND_RELEASE, 3'd0, 8'd1, 32'h0);
    send_item(rhp_pkg::KIND_GET, 3'd0, 8'd1, 32'h0);
    send_item(rhp_pkg::KIND_DESTROY, 3'd0, 8'd1, 32'h0);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, 32'h5A5A_5A5A);
    configure(4'd2, 1'b0, 1'b1);
    send_item(rhp_pkg::KIND_GET, 3'd5, 8'd3, 32'h0);
    send_item(rhp_pkg::KIND_DESTROY, 3'd0, 8'd0, 32'h0);
    configure(4'd0, 1'b1, 1'b0);
    send_item(rhp_pkg::KIND_GET, 3'd1, 8'd0, 32'h0);
    configure(4'd15, 1'b1, 1'b0);
    send_item(rhp_pkg::KIND_GET, 3'd7, 8'd0, 32'h0);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, $urandom);

    configure(4'd1, 1'b1, 1'b0);
    repeat (3) send_item(rhp_pkg::KIND_GET, 3'd0, 8'd2, $urandom);
    configure(4'd1, 1'b1, 1'b1);
    send_item(rhp_pkg::KIND_GET, 3'd0, 8'd2, 32'h0);
    configure(4'd1, 1'b1, 1'b0);
    send_item(rhp_pkg::KIND_RELEASE, 3'd0, 8'd2, 32'h0);
    send_item(rhp_pkg::KIND_GET, 3'd0, 8'd2, 32'h0);

    // fill arenas, skip a full one, stale search start, wrap around
    idle_on = 1'b1;
    repeat (SLOTS - 3) send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, $urandom);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, $urandom);
    configure(4'd1, 1'b1, 1'b1);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, $urandom);
    configure(4'd3, 1'b1, 1'b0);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, $urandom);
    configure(4'd1, 1'b1, 1'b0);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, $urandom);
    configure(4'd2, 1'b1, 1'b0);
    send_item(rhp_pkg::KIND_RELEASE, 3'd0, 8'd1, 32'h0);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, $urandom);
    repeat (SLOTS - 2) send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, $urandom);
    send_item(rhp_pkg::KIND_CREATE, 3'd0, 8'd0, $urandom);

    for (int p = 0; p < 10; p++) begin
      configure(ARENA_PLAN[p], p % 3 != 2, p % 4 == 3);
      if (p == 3) hold_cycles = HOLD_OFF_CYCLES;
      repeat (50) random_item();
    end

    drain();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* refcounted_handle_pool_core.f */
rtl/core/rhp_pkg.sv
rtl/core/rhp_bitmap.sv
rtl/core/refcounted_handle_pool_core.sv
tb/sv/refcounted_handle_pool_core_test.sv
